[hw/rtl/shash_pkg.sv]
// Shared types and constants for the SHA-256 stream hasher.
// Holds the round constants, the initial hash values and the core control structs.
// No dependencies.
package shash_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int WORD_BITS   = 32;
	localparam int NUM_WORDS   = 8;
	localparam int ROUNDS      = 64;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	// Input item kinds carried on tuser.
	localparam logic CMD_ABSORB = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	localparam logic [31:0] K_TABLE [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [NUM_WORDS-1:0][31:0] H_INIT = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	typedef struct packed {
		logic       push;
		logic [7:0] byte_val;
		logic       reinit;
	} core_ctrl_t;

	typedef struct packed {
		logic       busy;
		logic [5:0] fill;
	} core_stat_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_PAD  = 5'b00010,
		S_LEN  = 5'b00100,
		S_WAIT = 5'b01000,
		S_OUT  = 5'b10000
	} seq_state_t;

endpackage

[hw/rtl/shash_core.sv]
// SHA-256 compression core: byte-wide block window, message schedule and one round unit.
// The round unit runs once per cycle, one round at a time, then the chaining words are updated.
// Depends on shash_pkg.
module shash_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  shash_pkg::core_ctrl_t    ctrl,
	output shash_pkg::core_stat_t    stat,
	output logic [shash_pkg::NUM_WORDS-1:0][31:0] hash
);

	typedef enum logic [2:0] {
		C_IDLE  = 3'b001,
		C_ROUND = 3'b010,
		C_ADD   = 3'b100
	} core_state_t;

	core_state_t state_q;
	logic [511:0] blk_q;
	logic [5:0]   fill_q;
	logic [5:0]   rnd_q;
	logic [shash_pkg::NUM_WORDS-1:0][31:0] v_q;
	logic [shash_pkg::NUM_WORDS-1:0][31:0] h_q;

	logic [31:0] w0, w1, w9, w14, w_new, s0, s1;
	logic [31:0] big0, big1, choose, major, t1, t2;
	logic        start;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// The window holds the sixteen schedule words, the oldest in the top bits.
	assign w0  = blk_q[511:480];
	assign w1  = blk_q[479:448];
	assign w9  = blk_q[223:192];
	assign w14 = blk_q[63:32];

	assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
	assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
	assign w_new = s1 + w9 + s0 + w0;

	assign big1   = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
	assign choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign t1     = v_q[7] + big1 + choose + shash_pkg::K_TABLE[rnd_q] + w0;
	assign big0   = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
	assign major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t2     = big0 + major;

	assign start = ctrl.push && (fill_q == 6'd63);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			fill_q  <= '0;
			rnd_q   <= '0;
			h_q     <= shash_pkg::H_INIT;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (ctrl.push) begin
						fill_q <= fill_q + 6'd1;
					end
					if (start) begin
						rnd_q   <= '0;
						state_q <= C_ROUND;
					end
					if (ctrl.reinit) begin
						h_q <= shash_pkg::H_INIT;
					end
				end
				C_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= C_ADD;
					end
				end
				C_ADD: begin
					for (int i = 0; i < shash_pkg::NUM_WORDS; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && ctrl.push) begin
			blk_q <= {blk_q[503:0], ctrl.byte_val};
		end else if (state_q == C_ROUND) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (start) begin
			v_q <= h_q;
		end else if (state_q == C_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign stat.busy = (state_q != C_IDLE);
	assign stat.fill = fill_q;
	assign hash      = h_q;

	a_start_round: assert property (@(posedge clk) disable iff (!arst_n)
		start && state_q == C_IDLE |=> state_q == C_ROUND && rnd_q == 6'd0)
		else $error("compression did not start at round zero");

	a_round_to_add: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == C_ROUND && rnd_q == 6'd63 |=> state_q == C_ADD)
		else $error("round 63 not followed by the chaining update");

	a_add_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == C_ADD |=> state_q == C_IDLE && fill_q == 6'd0)
		else $error("block finished with a nonzero fill count");

	a_no_push_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != C_IDLE |-> !ctrl.push && !ctrl.reinit)
		else $error("byte pushed or hash reset during compression");

endmodule

[hw/rtl/sha256_stream_hasher_unit.sv]
// Input: a byte item is accepted while the core is idle; the 64th byte of a block starts a
// compression that holds s_tready low for the 64 rounds of the shared round unit plus the
// chaining update. Finish: padding bytes go in one per cycle while the core is idle,
// with one or two compressions, then the eight digest words leave one per cycle while
// m_tready is high. Reset (arst_n low) restores the initial hash values and clears the
// length and fill counts; the block buffer itself is not cleared.
module sha256_stream_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
	output logic        m_tlast
);

	shash_pkg::seq_state_t state_q;
	shash_pkg::core_ctrl_t ctrl;
	shash_pkg::core_stat_t stat;
	logic [shash_pkg::NUM_WORDS-1:0][31:0] hash;

	logic [63:0] len_q;
	logic [63:0] len_sh_q;
	logic [2:0]  cnt_q;
	logic [2:0]  widx_q;
	logic        in_acc;

	assign s_tready = (state_q == shash_pkg::S_IDLE) && !stat.busy;
	assign in_acc   = s_tvalid && s_tready;

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			shash_pkg::S_IDLE: begin
				ctrl.push     = in_acc;
				ctrl.byte_val = (s_tuser == shash_pkg::CMD_FINISH) ? shash_pkg::PAD_BYTE : s_tdata;
			end
			shash_pkg::S_PAD: begin
				ctrl.push = !stat.busy && (stat.fill != shash_pkg::LEN_POS);
			end
			shash_pkg::S_LEN: begin
				ctrl.push     = !stat.busy;
				ctrl.byte_val = len_sh_q[63:56];
			end
			shash_pkg::S_OUT: begin
				ctrl.reinit = m_tready && (widx_q == 3'd7);
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shash_pkg::S_IDLE;
			len_q   <= '0;
			cnt_q   <= '0;
			widx_q  <= '0;
		end else begin
			unique case (state_q)
				shash_pkg::S_IDLE: begin
					if (in_acc) begin
						if (s_tuser == shash_pkg::CMD_FINISH) begin
							len_q   <= '0;
							state_q <= shash_pkg::S_PAD;
						end else begin
							len_q <= len_q + 64'd8;
						end
					end
				end
				shash_pkg::S_PAD: begin
					if (!stat.busy && stat.fill == shash_pkg::LEN_POS) begin
						cnt_q   <= '0;
						state_q <= shash_pkg::S_LEN;
					end
				end
				shash_pkg::S_LEN: begin
					if (!stat.busy) begin
						cnt_q <= cnt_q + 3'd1;
						if (cnt_q == 3'd7) begin
							state_q <= shash_pkg::S_WAIT;
						end
					end
				end
				shash_pkg::S_WAIT: begin
					if (!stat.busy) begin
						widx_q  <= '0;
						state_q <= shash_pkg::S_OUT;
					end
				end
				shash_pkg::S_OUT: begin
					if (m_tready) begin
						widx_q <= widx_q + 3'd1;
						if (widx_q == 3'd7) begin
							state_q <= shash_pkg::S_IDLE;
						end
					end
				end
				default: begin
					state_q <= shash_pkg::S_IDLE;
				end
			endcase
		end
	end

	// The length snapshot shifts out most significant byte first.
	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == shash_pkg::CMD_FINISH) begin
			len_sh_q <= len_q;
		end else if (state_q == shash_pkg::S_LEN && !stat.busy) begin
			len_sh_q <= {len_sh_q[55:0], 8'h00};
		end
	end

	shash_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat),
		.hash   (hash)
	);

	assign m_tvalid = (state_q == shash_pkg::S_OUT);
	assign m_tdata  = {5'b00000, widx_q, hash[widx_q]};
	assign m_tlast  = (widx_q == 3'd7);

endmodule

[bench/tb_sha256_stream_hasher_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sha256_stream_hasher_unit: byte streams in, digest words out.
// Holds its own SHA-256 model in a small scoreboard class; depends on shash_pkg and the DUT.
module tb_sha256_stream_hasher_unit;

	localparam int        CYCLE_LIMIT = 400000;
	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam int        LEN_OFFSET  = 56;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	class sha256_digest_tracker;
		logic [31:0]  chain [8];
		logic [7:0]   block_bytes [64];
		int unsigned  fill;
		logic [63:0]  msg_bits;
		digest_word_t owed_words [$];
		int unsigned  mismatches;

		function new();
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			chain = SHA_IV;
			fill = 0;
			msg_bits = '0;
		endfunction

		function logic [31:0] rotr(logic [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			logic [31:0] w [64];
			logic [31:0] v [8];
			logic [31:0] s0, s1, ch, mj, t1;
			for (int i = 0; i < 16; i++)
				w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
					block_bytes[4*i+3]};
			for (int i = 16; i < 64; i++) begin
				s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = s1 + w[i-7] + s0 + w[i-16];
			end
			v = chain;
			for (int i = 0; i < 64; i++) begin
				s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
				ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
				t1 = v[7] + s1 + ch + ROUND_K[i] + w[i];
				s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
				mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + s0 + mj;
			end
			for (int i = 0; i < 8; i++)
				chain[i] = chain[i] + v[i];
		endfunction

		function void absorb(logic [7:0] b);
			block_bytes[fill] = b;
			fill = (fill + 1) % 64;
			if (fill == 0)
				compress();
		endfunction

		// Called for every accepted input item.
		function void note_item(logic cmd, logic [7:0] b);
			logic [63:0]  len;
			digest_word_t dw;
			if (cmd == shash_pkg::CMD_ABSORB) begin
				msg_bits = msg_bits + 64'd8;
				absorb(b);
			end else begin
				len = msg_bits;
				absorb(PAD_MARK);
				while (fill != LEN_OFFSET)
					absorb(8'h00);
				for (int i = 0; i < 8; i++)
					absorb(len[63 - 8*i -: 8]);
				for (int i = 0; i < 8; i++) begin
					dw.word = chain[i];
					dw.index = i[2:0];
					dw.last = (i == 7);
					owed_words.push_back(dw);
				end
				restart();
			end
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] %s", $time, msg);
		endfunction

		// Called for every accepted result item.
		function void check_word(logic [39:0] tdata, logic tlast);
			digest_word_t want;
			if (owed_words.size() == 0) begin
				flag($sformatf("digest word %h (index %0d) arrived with none owed",
					tdata[31:0], tdata[34:32]));
				return;
			end
			want = owed_words.pop_front();
			if (tdata[31:0] !== want.word || tdata[34:32] !== want.index || tlast !== want.last)
				flag($sformatf("expected word %h index %0d last %0b, got word %h index %0d last %0b",
					want.word, want.index, want.last, tdata[31:0], tdata[34:32], tlast));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = shash_pkg::CMD_ABSORB;
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [39:0] m_tdata;
	logic        m_tlast;

	sha256_digest_tracker digests = new();
	bit          quiet_tail = 1'b0;
	int unsigned items_sent = 0;
	int unsigned finishes_sent = 0;
	int unsigned cycle_count = 0;

	sha256_stream_hasher_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			digests.check_word(m_tdata, m_tlast);
	end

	// Downstream back-pressure in random bursts.
	always begin
		@(posedge clk);
		if (!quiet_tail && $urandom_range(0, 9) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
			m_tready <= 1'b1;
		end
	end

	task automatic push_item(input logic cmd, input logic [7:0] b);
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		digests.note_item(cmd, b);
		items_sent++;
		if (cmd == shash_pkg::CMD_FINISH)
			finishes_sent++;
	endtask

	task automatic send_message(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			push_item(shash_pkg::CMD_ABSORB, 8'($urandom));
		push_item(shash_pkg::CMD_FINISH, 8'($urandom));
	endtask

	// Holds the sender off until every owed digest word has come back.
	task automatic wait_for_digests();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (digests.owed_words.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned msg_count;
		int unsigned len;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty messages, then short ones; the data byte of a finish item is ignored.
		push_item(shash_pkg::CMD_FINISH, 8'h00);
		push_item(shash_pkg::CMD_FINISH, 8'hff);
		push_item(shash_pkg::CMD_ABSORB, "a");
		push_item(shash_pkg::CMD_ABSORB, "b");
		push_item(shash_pkg::CMD_ABSORB, "c");
		push_item(shash_pkg::CMD_FINISH, 8'ha5);
		push_item(shash_pkg::CMD_ABSORB, 8'h00);
		push_item(shash_pkg::CMD_ABSORB, 8'hff);
		push_item(shash_pkg::CMD_FINISH, 8'h5a);
		push_item(shash_pkg::CMD_ABSORB, PAD_MARK);
		push_item(shash_pkg::CMD_FINISH, 8'h00);
		wait_for_digests();

		// Lengths 55, 56 and 64 cover the one-block pad, the extra pad block
		// and a full block compressed before the pad.
		msg_count = 0;
		while (items_sent < 185 || finishes_sent < 12) begin
			case (msg_count)
				1: len = 55;
				3: len = 56;
				5: len = 64;
				default: len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 70)
					: $urandom_range(0, 12);
			endcase
			if (items_sent >= 150)
				quiet_tail = 1'b1;
			send_message(len);
			msg_count++;
			if ($urandom_range(0, 4) == 0)
				wait_for_digests();
		end
		s_tvalid <= 1'b0;

		while (digests.owed_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (digests.mismatches == 0 && digests.owed_words.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
hw/rtl/shash_pkg.sv
hw/rtl/shash_core.sv
hw/rtl/sha256_stream_hasher_unit.sv
bench/tb_sha256_stream_hasher_unit.sv
